// ===== rtl/rc4_stream_cipher_unit_macros.svh =====
// Assertion macros shared by the cipher unit.
`ifndef RC4_STREAM_CIPHER_UNIT_MACROS_SVH
`define RC4_STREAM_CIPHER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RC4_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rc4_pkg.sv =====
// Types and constants shared by the RC4 cipher unit modules.
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int SBOX_DEPTH    = 256;
    localparam int SBOX_AW       = $clog2(SBOX_DEPTH);
    localparam int KEY_W         = 64;
    localparam int LEN_W         = 5;
    localparam int MAX_KEY_BYTES = 16;
    localparam int KIDX_W        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int CFG_IDX_W     = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

    localparam logic [LEN_W-1:0] KEY_LEN_RESET = 5'd1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_KS_START,
        OP_INIT_WR,
        OP_KSA_RD_I,
        OP_KSA_RD_J,
        OP_KSA_WR_I,
        OP_KSA_WR_J,
        OP_PR_RD_I,
        OP_PR_RD_J,
        OP_PR_WR_I,
        OP_PR_WR_J,
        OP_PR_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KSA_RD_I,
        ST_KSA_RD_J,
        ST_KSA_WR_I,
        ST_KSA_WR_J,
        ST_PR_RD_I,
        ST_PR_RD_J,
        ST_PR_WR_I,
        ST_PR_WR_J,
        ST_PR_OUT
    } rc4_state_t;

    typedef struct packed {
        logic   load_item;
        dp_op_t op;
    } rc4_cmd_t;

    typedef struct packed {
        logic k_last;
    } rc4_status_t;

endpackage

// ===== rtl/rc4_ram.sv =====
// Generic single-write, single-read RAM with registered read-first output.
`timescale 1ns / 1ps

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read of the address written in the same cycle returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rc4_datapath.sv =====
// Datapath: key registers, S-box memory, step counters and output register.
`timescale 1ns / 1ps

module rc4_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_enable,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rc4_pkg::KEY_W-1:0]             cfg_data,
    input  logic [rc4_pkg::BYTE_W-1:0]            data_byte,
    input  rc4_pkg::rc4_cmd_t                     cmd,
    output rc4_pkg::rc4_status_t                  status,
    output logic [rc4_pkg::BYTE_W-1:0]            out_byte
);

    logic [rc4_pkg::KEY_W-1:0]   key_low_reg;
    logic [rc4_pkg::KEY_W-1:0]   key_high_reg;
    logic [rc4_pkg::LEN_W-1:0]   key_len_reg;

    logic [rc4_pkg::SBOX_AW-1:0] k_reg, k_next;
    logic [rc4_pkg::KIDX_W-1:0]  kidx_reg, kidx_next;
    logic [rc4_pkg::SBOX_AW-1:0] i_reg, i_next;
    logic [rc4_pkg::SBOX_AW-1:0] j_reg, j_next;
    logic [rc4_pkg::BYTE_W-1:0]  si_reg, si_next;
    logic [rc4_pkg::BYTE_W-1:0]  sj_reg, sj_next;
    logic                        hit_reg, hit_next;
    logic [rc4_pkg::BYTE_W-1:0]  data_reg, data_next;
    logic [rc4_pkg::BYTE_W-1:0]  result_reg, result_next;

    logic                        wr_en;
    logic [rc4_pkg::SBOX_AW-1:0] wr_addr;
    logic [rc4_pkg::BYTE_W-1:0]  wr_data;
    logic                        rd_en;
    logic [rc4_pkg::SBOX_AW-1:0] rd_addr;
    logic [rc4_pkg::BYTE_W-1:0]  rd_data;

    logic [rc4_pkg::LEN_W-1:0]   len_eff;
    logic [rc4_pkg::KIDX_W-1:0]  kidx_last;
    logic [2*rc4_pkg::KEY_W-1:0] key_all;
    logic [rc4_pkg::BYTE_W-1:0]  key_byte;
    logic [rc4_pkg::SBOX_AW-1:0] ksa_j;
    logic [rc4_pkg::SBOX_AW-1:0] prga_j;
    logic [rc4_pkg::SBOX_AW-1:0] t_addr;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= rc4_pkg::KEY_LEN_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                rc4_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                rc4_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                rc4_pkg::CFG_KEY_LEN:  key_len_reg  <= cfg_data[rc4_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero length counts as one byte, and the length saturates at the key size.
    always_comb
    begin
        if (key_len_reg == '0)
        begin
            len_eff = rc4_pkg::LEN_W'(1);
        end
        else if (key_len_reg > rc4_pkg::LEN_W'(rc4_pkg::MAX_KEY_BYTES))
        begin
            len_eff = rc4_pkg::LEN_W'(rc4_pkg::MAX_KEY_BYTES);
        end
        else
        begin
            len_eff = key_len_reg;
        end
    end

    assign kidx_last = rc4_pkg::KIDX_W'(len_eff - rc4_pkg::LEN_W'(1));
    assign key_all   = {key_high_reg, key_low_reg};
    assign key_byte  = key_all[kidx_reg*rc4_pkg::BYTE_W +: rc4_pkg::BYTE_W];
    assign ksa_j     = j_reg + rd_data + key_byte;
    assign prga_j    = j_reg + rd_data;
    assign t_addr    = si_reg + sj_reg;

    always_comb
    begin
        k_next      = k_reg;
        kidx_next   = kidx_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        si_next     = si_reg;
        sj_next     = sj_reg;
        hit_next    = hit_reg;
        result_next = result_reg;
        data_next   = cmd.load_item ? data_byte : data_reg;
        wr_en       = 1'b0;
        wr_addr     = k_reg;
        wr_data     = k_reg;
        rd_en       = 1'b0;
        rd_addr     = k_reg;

        unique case (cmd.op)
            rc4_pkg::OP_NONE:
            begin
            end
            rc4_pkg::OP_KS_START:
            begin
                k_next    = '0;
                kidx_next = '0;
                j_next    = '0;
            end
            rc4_pkg::OP_INIT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg;
                wr_data = k_reg;
                k_next  = k_reg + 1'b1;
            end
            rc4_pkg::OP_KSA_RD_I:
            begin
                rd_en   = 1'b1;
                rd_addr = k_reg;
            end
            rc4_pkg::OP_KSA_RD_J:
            begin
                si_next = rd_data;
                j_next  = ksa_j;
                rd_en   = 1'b1;
                rd_addr = ksa_j;
            end
            rc4_pkg::OP_KSA_WR_I:
            begin
                sj_next = rd_data;
                wr_en   = 1'b1;
                wr_addr = k_reg;
                wr_data = rd_data;
            end
            rc4_pkg::OP_KSA_WR_J:
            begin
                wr_en     = 1'b1;
                wr_addr   = j_reg;
                wr_data   = si_reg;
                k_next    = k_reg + 1'b1;
                kidx_next = (kidx_reg == kidx_last) ? '0 : kidx_reg + 1'b1;
                // The step counters start from zero once the schedule ends.
                if (status.k_last)
                begin
                    i_next = '0;
                    j_next = '0;
                end
            end
            rc4_pkg::OP_PR_RD_I:
            begin
                i_next  = i_reg + 1'b1;
                rd_en   = 1'b1;
                rd_addr = i_reg + 1'b1;
            end
            rc4_pkg::OP_PR_RD_J:
            begin
                si_next = rd_data;
                j_next  = prga_j;
                rd_en   = 1'b1;
                rd_addr = prga_j;
            end
            rc4_pkg::OP_PR_WR_I:
            begin
                sj_next = rd_data;
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = rd_data;
            end
            rc4_pkg::OP_PR_WR_J:
            begin
                // The read of the keystream entry sees the old value at j,
                // so a hit on j is forwarded from the swap register.
                wr_en    = 1'b1;
                wr_addr  = j_reg;
                wr_data  = si_reg;
                rd_en    = 1'b1;
                rd_addr  = t_addr;
                hit_next = (t_addr == j_reg);
            end
            rc4_pkg::OP_PR_OUT:
            begin
                result_next = data_reg ^ (hit_reg ? si_reg : rd_data);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        si_reg     <= si_next;
        sj_reg     <= sj_next;
        hit_reg    <= hit_next;
        data_reg   <= data_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= '0;
            kidx_reg <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
        end
        else
        begin
            k_reg    <= k_next;
            kidx_reg <= kidx_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
        end
    end

    rc4_ram #(
        .WIDTH (rc4_pkg::BYTE_W),
        .DEPTH (rc4_pkg::SBOX_DEPTH)
    ) u_sbox (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign status.k_last = (k_reg == '1);
    assign out_byte      = result_reg;

endmodule

// ===== rtl/rc4_ctrl.sv =====
// Controller: sequences the key schedule and the keystream steps for each item.
`timescale 1ns / 1ps

module rc4_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 message_start,
    input  logic                 out_stall,
    input  rc4_pkg::rc4_status_t status,
    output rc4_pkg::rc4_cmd_t    cmd,
    output logic                 in_stall,
    output logic                 out_valid
);

    rc4_pkg::rc4_state_t state_reg, state_next;
    logic                scheduled_reg, scheduled_next;
    logic                out_valid_reg, out_valid_next;
    logic                need_ks;
    logic                slot_free;

    assign need_ks   = message_start || !scheduled_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = need_ks ? rc4_pkg::ST_INIT : rc4_pkg::ST_PR_RD_I;
                end
            end
            rc4_pkg::ST_INIT:
            begin
                if (status.k_last)
                begin
                    state_next = rc4_pkg::ST_KSA_RD_I;
                end
            end
            rc4_pkg::ST_KSA_RD_I: state_next = rc4_pkg::ST_KSA_RD_J;
            rc4_pkg::ST_KSA_RD_J: state_next = rc4_pkg::ST_KSA_WR_I;
            rc4_pkg::ST_KSA_WR_I: state_next = rc4_pkg::ST_KSA_WR_J;
            rc4_pkg::ST_KSA_WR_J:
            begin
                state_next = status.k_last ? rc4_pkg::ST_PR_RD_I : rc4_pkg::ST_KSA_RD_I;
            end
            rc4_pkg::ST_PR_RD_I:  state_next = rc4_pkg::ST_PR_RD_J;
            rc4_pkg::ST_PR_RD_J:  state_next = rc4_pkg::ST_PR_WR_I;
            rc4_pkg::ST_PR_WR_I:  state_next = rc4_pkg::ST_PR_WR_J;
            rc4_pkg::ST_PR_WR_J:  state_next = rc4_pkg::ST_PR_OUT;
            rc4_pkg::ST_PR_OUT:
            begin
                if (slot_free)
                begin
                    state_next = rc4_pkg::ST_IDLE;
                end
            end
            default: state_next = rc4_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load_item  = 1'b0;
        cmd.op         = rc4_pkg::OP_NONE;
        scheduled_next = scheduled_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    cmd.op        = need_ks ? rc4_pkg::OP_KS_START : rc4_pkg::OP_NONE;
                end
            end
            rc4_pkg::ST_INIT:     cmd.op = rc4_pkg::OP_INIT_WR;
            rc4_pkg::ST_KSA_RD_I: cmd.op = rc4_pkg::OP_KSA_RD_I;
            rc4_pkg::ST_KSA_RD_J: cmd.op = rc4_pkg::OP_KSA_RD_J;
            rc4_pkg::ST_KSA_WR_I: cmd.op = rc4_pkg::OP_KSA_WR_I;
            rc4_pkg::ST_KSA_WR_J:
            begin
                cmd.op = rc4_pkg::OP_KSA_WR_J;
                if (status.k_last)
                begin
                    scheduled_next = 1'b1;
                end
            end
            rc4_pkg::ST_PR_RD_I:  cmd.op = rc4_pkg::OP_PR_RD_I;
            rc4_pkg::ST_PR_RD_J:  cmd.op = rc4_pkg::OP_PR_RD_J;
            rc4_pkg::ST_PR_WR_I:  cmd.op = rc4_pkg::OP_PR_WR_I;
            rc4_pkg::ST_PR_WR_J:  cmd.op = rc4_pkg::OP_PR_WR_J;
            rc4_pkg::ST_PR_OUT:
            begin
                if (slot_free)
                begin
                    cmd.op         = rc4_pkg::OP_PR_OUT;
                    out_valid_next = 1'b1;
                end
            end
            default: cmd.op = rc4_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4_pkg::ST_IDLE;
            scheduled_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scheduled_reg <= scheduled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != rc4_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/rc4_stream_cipher_unit.sv =====
// RC4 stream cipher unit: top level joining the controller and the datapath.
// A new item is taken only once the result of the last one has been registered; the keystream
// steps share the single read port of the S-box memory (two reads, two writes and one more read).
// A message start, and the first item after reset, first runs the key schedule: an identity
// fill of all 256 S-box entries, then 256 swap steps (read i, read j, write i, write j).
// Reset clears the controller, the counters and the key words, and sets the key length to one.
`timescale 1ns / 1ps
`include "rc4_stream_cipher_unit_macros.svh"

module rc4_stream_cipher_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_enable,
    input  logic [rc4_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rc4_pkg::KEY_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rc4_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          message_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rc4_pkg::BYTE_W-1:0]    out_byte
);

    rc4_pkg::rc4_cmd_t    cmd;
    rc4_pkg::rc4_status_t status;

    rc4_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .message_start (message_start),
        .out_stall     (out_stall),
        .status        (status),
        .cmd           (cmd),
        .in_stall      (in_stall),
        .out_valid     (out_valid)
    );

    rc4_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .data_byte        (data_byte),
        .cmd              (cmd),
        .status           (status),
        .out_byte         (out_byte)
    );

    `RC4_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "item accepted but block not busy")
    `RC4_ASSERT_IMP(a_no_overwrite, out_valid && out_stall, cmd.op != rc4_pkg::OP_PR_OUT, "held result overwritten")
    `RC4_ASSERT_IMP(a_result_source, $rose(out_valid), $past(cmd.op == rc4_pkg::OP_PR_OUT), "result without keystream step")
    `RC4_ASSERT_NEXT(a_result_shown, cmd.op == rc4_pkg::OP_PR_OUT, out_valid, "finished result not presented")

endmodule
